[src/etu_pkg.sv]
// ----------------------------------------------------------------------------
// etu_pkg
// Shared types and constants of the escaped text unescaper.
// ----------------------------------------------------------------------------
`default_nettype none

package etu_pkg;

  // Field widths
  localparam int unsigned ByteW  = 8;
  localparam int unsigned CountW = 8;
  localparam int unsigned SkipW  = 2;

  // Depth of the record queue between front and back
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // Reset value of the character limit
  localparam logic [CountW-1:0] MaxCharsReset = 8'd63;

  // Byte codes
  localparam logic [ByteW-1:0] ChSpace     = 8'h20;
  localparam logic [ByteW-1:0] ChBackslash = 8'h5C;
  localparam logic [ByteW-1:0] ChLowerN    = 8'h6E;
  localparam logic [ByteW-1:0] ChUpperN    = 8'h4E;
  localparam logic [ByteW-1:0] ChComma     = 8'h2C;
  localparam logic [ByteW-1:0] ChSemicolon = 8'h3B;
  localparam logic [ByteW-1:0] ChNull      = 8'h00;

  // UTF-8 lead byte classes
  localparam logic [ByteW-1:0] Lead3Mask = 8'hF0;
  localparam logic [ByteW-1:0] Lead3Code = 8'hE0;
  localparam logic [ByteW-1:0] Lead4Mask = 8'hF8;
  localparam logic [ByteW-1:0] Lead4Code = 8'hF0;

  // Continuation bytes to drop after a lead byte
  localparam logic [SkipW-1:0] SkipLead3 = 2'd2;
  localparam logic [SkipW-1:0] SkipLead4 = 2'd3;

  // Input item
  typedef struct packed {
    logic [ByteW-1:0] in_byte;
    logic             in_last;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             out_valid;
    logic             out_last;
  } out_item_t;

  // One record per input item that yields results: one or two of them
  typedef struct packed {
    logic             two;    // two characters: byte0 then byte1
    logic             valid0; // byte0 is a character (0: end marker)
    logic [ByteW-1:0] byte0;
    logic [ByteW-1:0] byte1;
    logic             last;   // last flag goes on the final result
  } rec_t;

endpackage

`default_nettype wire

[src/etu_front.sv]
// ----------------------------------------------------------------------------
// etu_front
// Classifies each input byte, tracks skip, escape and count state, and
// turns the byte into a result record for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module etu_front (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [etu_pkg::CountW-1:0]  cfg_wdata_i,
  input  wire logic                        in_fire_i,
  input  wire etu_pkg::in_item_t           in_item_i,
  output logic                             push_o,
  output etu_pkg::rec_t                    rec_o
);

  logic [etu_pkg::CountW-1:0] max_q;
  logic [etu_pkg::SkipW-1:0]  skip_q, skip_d;
  logic                       esc_q, esc_d;
  logic [etu_pkg::CountW-1:0] cw_q, cw_d;
  logic                       ts_q, ts_d;

  logic [etu_pkg::ByteW-1:0]  b;
  logic                       last;
  logic                       w1, w2;
  logic [etu_pkg::ByteW-1:0]  c1, c2;
  logic                       ok1, ok2, e1, e2, ts1, ts2;
  logic [etu_pkg::CountW-1:0] cw1, cw2;

  assign b    = in_item_i.in_byte;
  assign last = in_item_i.in_last;

  // Classify the byte and pick up to two candidate characters
  always_comb begin
    skip_d = skip_q;
    esc_d  = esc_q;
    w1     = 1'b0;
    w2     = 1'b0;
    c1     = b;
    c2     = b;
    if (skip_q != '0) begin
      skip_d = skip_q - 2'd1;
    end else if (esc_q) begin
      esc_d = 1'b0;
      if (b == etu_pkg::ChLowerN || b == etu_pkg::ChUpperN) begin
        w1 = 1'b1;
        c1 = etu_pkg::ChSpace;
      end else if (b == etu_pkg::ChComma || b == etu_pkg::ChSemicolon ||
                   b == etu_pkg::ChBackslash) begin
        w1 = 1'b1;
      end else begin
        // Unknown escape: keep the backslash and its partner
        w1 = 1'b1;
        c1 = etu_pkg::ChBackslash;
        w2 = 1'b1;
      end
    end else if ((b & etu_pkg::Lead3Mask) == etu_pkg::Lead3Code) begin
      skip_d = etu_pkg::SkipLead3;
    end else if ((b & etu_pkg::Lead4Mask) == etu_pkg::Lead4Code) begin
      skip_d = etu_pkg::SkipLead4;
    end else if (b == etu_pkg::ChBackslash && !last) begin
      esc_d = 1'b1;
    end else begin
      w1 = 1'b1;
    end
  end

  // Apply limit and leading space trim to each candidate in turn
  always_comb begin
    ok1 = w1 && (cw_q < max_q);
    cw1 = cw_q + {{(etu_pkg::CountW-1){1'b0}}, ok1};
    e1  = ok1 && !(c1 == etu_pkg::ChSpace && !ts_q);
    ts1 = ts_q | e1;
    ok2 = w2 && (cw1 < max_q);
    cw2 = cw1 + {{(etu_pkg::CountW-1){1'b0}}, ok2};
    e2  = ok2 && !(c2 == etu_pkg::ChSpace && !ts1);
    ts2 = ts1 | e2;
    cw_d = cw2;
    ts_d = ts2;
  end

  // Build the record; an item with no character on the last byte is a marker
  always_comb begin
    push_o       = in_fire_i && (e1 || e2 || last);
    rec_o.two    = e1 && e2;
    rec_o.valid0 = e1 || e2;
    rec_o.byte0  = e1 ? c1 : (e2 ? c2 : etu_pkg::ChNull);
    rec_o.byte1  = c2;
    rec_o.last   = last;
  end

  // Hold the limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= etu_pkg::MaxCharsReset;
    end else if (cfg_we_i) begin
      max_q <= cfg_wdata_i;
    end
  end

  // Advance stream state, clear it after the last byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_q <= '0;
      esc_q  <= 1'b0;
      cw_q   <= '0;
      ts_q   <= 1'b0;
    end else if (in_fire_i) begin
      if (last) begin
        skip_q <= '0;
        esc_q  <= 1'b0;
        cw_q   <= '0;
        ts_q   <= 1'b0;
      end else begin
        skip_q <= skip_d;
        esc_q  <= esc_d;
        cw_q   <= cw_d;
        ts_q   <= ts_d;
      end
    end
  end

`ifndef SYNTHESIS
  // Skipping continuation bytes and a pending escape never coexist
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !((skip_q != '0) && esc_q))
    else $error("etu_front: skip and escape pending together");
`endif

endmodule

`default_nettype wire

[src/etu_fifo.sv]
// ----------------------------------------------------------------------------
// etu_fifo
// Short register queue of result records between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module etu_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire etu_pkg::rec_t push_rec_i,
  output logic               full_o,
  output logic               head_valid_o,
  output etu_pkg::rec_t      head_rec_o,
  input  wire logic          pop_i
);

  etu_pkg::rec_t                  mem_q [etu_pkg::QDepth];
  logic [etu_pkg::QPtrW-1:0]      wr_q, rd_q;
  logic [etu_pkg::QCntW-1:0]      cnt_q;

  assign full_o       = (cnt_q == etu_pkg::QCntW'(etu_pkg::QDepth));
  assign head_valid_o = (cnt_q != '0);
  assign head_rec_o   = mem_q[rd_q];

  // Store records
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_rec_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + etu_pkg::QPtrW'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + etu_pkg::QPtrW'(1);
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + etu_pkg::QCntW'(1);
        2'b01:   cnt_q <= cnt_q - etu_pkg::QCntW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

`ifndef SYNTHESIS
  // No write into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o)
    else $error("etu_fifo: push while full");
  // No read from an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> head_valid_o)
    else $error("etu_fifo: pop while empty");
`endif

endmodule

`default_nettype wire

[src/etu_back.sv]
// ----------------------------------------------------------------------------
// etu_back
// Unpacks queued records into result transfers through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module etu_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          head_valid_i,
  input  wire etu_pkg::rec_t head_rec_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output etu_pkg::out_item_t out_data_o
);

  logic               vld_q;
  logic               half_q, half_d;
  etu_pkg::out_item_t data_q, data_d;
  logic               load;

  // Load the output register when it is empty or being taken
  assign load = head_valid_i && (!vld_q || out_ready_i);

  // Pick the next result from the head record
  always_comb begin
    half_d          = half_q;
    pop_o           = 1'b0;
    data_d.out_byte = head_rec_i.byte0;
    data_d.out_valid = head_rec_i.valid0;
    data_d.out_last = head_rec_i.last;
    if (load) begin
      if (head_rec_i.two && !half_q) begin
        // First of two characters: keep the record
        data_d.out_valid = 1'b1;
        data_d.out_last  = 1'b0;
        half_d           = 1'b1;
      end else begin
        if (half_q) begin
          data_d.out_byte  = head_rec_i.byte1;
          data_d.out_valid = 1'b1;
        end
        half_d = 1'b0;
        pop_o  = 1'b1;
      end
    end
  end

  // Hold result payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_d;
    end
  end

  // Track output valid and record half
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      half_q <= 1'b0;
    end else begin
      half_q <= half_d;
      if (load) begin
        vld_q <= 1'b1;
      end else if (out_ready_i) begin
        vld_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = vld_q;
  assign out_data_o  = data_q;

`ifndef SYNTHESIS
  // Second half is only pending on a two-character record
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    half_q |-> (head_valid_i && head_rec_i.two))
    else $error("etu_back: half pending without two-character record");
`endif

endmodule

`default_nettype wire

[src/escaped_text_unescaper.sv]
// ----------------------------------------------------------------------------
// escaped_text_unescaper
// Escaped text value cleaner: 3/4-byte UTF-8 drop, escape decode, limit and trim.
// ----------------------------------------------------------------------------
// The block takes one input byte per clock while the queue has room. Each
// byte is classified and its results are decided in the cycle it is
// accepted; a byte that yields results writes one record into a four-entry
// queue, and the back end sends one result per clock while out_ready_i is
// high from an output register, so a result passes through the queue and
// then the output register before out_valid_o rises. An unknown escape
// yields up to two results; input stalls only while the queue is full.
// cfg_we_i writes the character limit (reset 63).
// ----------------------------------------------------------------------------
`default_nettype none

module escaped_text_unescaper (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [etu_pkg::CountW-1:0] cfg_wdata_i,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire etu_pkg::in_item_t          in_data_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output etu_pkg::out_item_t              out_data_o
);

  logic          push, pop, full, head_valid, in_fire;
  etu_pkg::rec_t push_rec, head_rec;

  // Accept while the queue has room
  assign in_ready_o = !full;
  assign in_fire    = in_valid_i && in_ready_o;

  etu_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_fire_i   (in_fire),
    .in_item_i   (in_data_i),
    .push_o      (push),
    .rec_o       (push_rec)
  );

  etu_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_rec_i   (push_rec),
    .full_o       (full),
    .head_valid_o (head_valid),
    .head_rec_o   (head_rec),
    .pop_i        (pop)
  );

  etu_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_rec_i   (head_rec),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

endmodule

`default_nettype wire
